FILE: hdl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// TLB page translation - shared definitions
// Field widths, default sizes and the structs exchanged with the TLB array.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Address split
  localparam int VA_W    = 16;
  localparam int PAGE_W  = 8;
  localparam int OFFS_W  = 8;
  localparam int FRAME_W = 8;
  localparam int PA_W    = FRAME_W + OFFS_W;

  // Counters
  localparam int                 HIT_W     = 16;
  localparam logic [HIT_W-1:0]   HIT_MAX   = {HIT_W{1'b1}};
  localparam int                 FUSED_W   = 9;
  localparam logic [FUSED_W-1:0] FUSED_MAX = {FUSED_W{1'b1}};

  // Default sizes
  localparam int DEF_TLB_ENTRIES = 16;
  localparam int DEF_PAGE_COUNT  = 256;

  // TLB search result
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_lookup_t;

  // TLB fill request (written at the FIFO pointer)
  typedef struct packed {
    logic               en;
    logic [PAGE_W-1:0]  tag;
    logic [FRAME_W-1:0] frame;
  } tlb_fill_t;

endpackage

FILE: hdl/tlbpt_in_if.sv
// ----------------------------------------------------------------------------
// TLB page translation - request channel
// Valid/ready channel carrying one virtual address per beat.
// ----------------------------------------------------------------------------
interface tlbpt_in_if;
  import tlbpt_pkg::*;

  logic            valid;
  logic            ready;
  logic [VA_W-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);

endinterface

FILE: hdl/tlbpt_out_if.sv
// ----------------------------------------------------------------------------
// TLB page translation - result channel
// Valid/ready channel carrying one translated address and its flags per beat.
// ----------------------------------------------------------------------------
interface tlbpt_out_if;
  import tlbpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [PA_W-1:0]  physical_address;
  logic             tlb_hit;
  logic             frame_allocated;
  logic [HIT_W-1:0] hit_count;

  modport source (output valid, output physical_address, output tlb_hit,
                  output frame_allocated, output hit_count, input ready);
  modport sink   (input valid, input physical_address, input tlb_hit,
                  input frame_allocated, input hit_count, output ready);

endinterface

FILE: hdl/tlb_page_translation.sv
// ----------------------------------------------------------------------------
// TLB page translation - top level
// Translates 16-bit virtual addresses through a FIFO TLB and a page map.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one virtual address per beat (page in 15..8, offset in 7..0).
//   out_chan : one result per address, in order: physical address, TLB hit,
//              new-frame flag and the saturating running hit count.
//   An accepted address is registered in stage 1, its result in the output
//   register behind out_chan.valid. One address per cycle is sustained
//   while out_chan does not stall: the page map is read at the accepting
//   edge, the TLB search and frame choice happen in the next cycle and the
//   result lands in the output register, which is where all state updates.
//   A back-to-back item that hits the map slot written by its predecessor
//   takes the frame from a bypass register.
//   After reset the page map is cleared one entry per cycle, so in_chan.ready
//   stays low until the pass ends; then TLB, map and counters are empty.
//   When out_chan stalls, the output register holds its beat and the single
//   item behind it waits; in_chan.ready drops until the output moves.
// ----------------------------------------------------------------------------
module tlb_page_translation #(
  parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
  parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT
) (
  input  logic         clk,
  input  logic         rst_n,
  tlbpt_in_if.sink     in_chan,
  tlbpt_out_if.source  out_chan
);
  import tlbpt_pkg::*;

  localparam int SLOT_W = $clog2(PAGE_COUNT);
  localparam int MOD_W  = SLOT_W + 4;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PAGE_COUNT - 1);
  localparam int MAP_W  = FRAME_W + 1;   // present bit on top of the frame

  // Page to map slot: identity for a full map, else page mod PAGE_COUNT
  // by four compare-subtract steps (exact while the quotient is below 16).
  function automatic logic [SLOT_W-1:0] slot_of(input logic [PAGE_W-1:0] page);
    logic [MOD_W-1:0] rem;
    rem = MOD_W'(page);
    if (PAGE_COUNT < (1 << PAGE_W)) begin
      for (int k = 3; k >= 0; k--) begin
        if (rem >= (MOD_W'(PAGE_COUNT) << k)) begin
          rem = rem - (MOD_W'(PAGE_COUNT) << k);
        end
      end
    end
    return SLOT_W'(rem);
  endfunction

  // Clearing pass
  logic              clr_active_r;
  logic [SLOT_W-1:0] clr_addr_r;

  // Stage 1 (address registered, map read in flight)
  logic              s1_valid_r;
  logic [VA_W-1:0]   s1_va_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              byp_r;
  logic [FRAME_W-1:0] byp_frame_r;

  // Page map memory
  logic [MAP_W-1:0]  map_mem [PAGE_COUNT];
  logic [MAP_W-1:0]  map_rd_r;
  logic              map_we;
  logic [SLOT_W-1:0] map_waddr;
  logic [MAP_W-1:0]  map_wdata;

  // Counters
  logic [HIT_W-1:0]   hit_total_r;
  logic [HIT_W-1:0]   hit_total_nxt;
  logic [FUSED_W-1:0] frames_used_r;

  // Output register
  logic               out_valid_r;
  logic [PA_W-1:0]    out_pa_r;
  logic               out_hit_r;
  logic               out_alloc_r;
  logic [HIT_W-1:0]   out_hits_r;

  // Stage 1 datapath
  logic               in_acc;
  logic               s1_adv;
  logic [SLOT_W-1:0]  in_slot;
  logic [PAGE_W-1:0]  s1_page;
  tlb_lookup_t        lk;
  tlb_fill_t          fill;
  logic               present;
  logic [FRAME_W-1:0] map_frame;
  logic               alloc;
  logic [FRAME_W-1:0] frame;
  logic               item_we;

  // Handshake
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_slot       = slot_of(in_chan.virtual_address[VA_W-1 -: PAGE_W]);

  // TLB
  assign s1_page    = s1_va_r[VA_W-1 -: PAGE_W];
  assign fill.en    = s1_adv && !lk.hit;
  assign fill.tag   = s1_page;
  assign fill.frame = frame;

  tlbpt_tlb #(
    .ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (s1_page),
    .lookup      (lk),
    .fill        (fill)
  );

  // Frame choice: TLB, then map (with bypass), then a fresh frame
  always_comb begin
    present   = byp_r || map_rd_r[FRAME_W];
    map_frame = byp_r ? byp_frame_r : map_rd_r[FRAME_W-1:0];
    alloc     = !lk.hit && !present;
    if (lk.hit) begin
      frame = lk.frame;
    end else if (present) begin
      frame = map_frame;
    end else begin
      frame = frames_used_r[FRAME_W-1:0];
    end
    hit_total_nxt = (lk.hit && (hit_total_r != HIT_MAX)) ? hit_total_r + 1'b1
                                                         : hit_total_r;
    item_we = s1_adv && alloc;
  end

  // Map write port: clearing pass or new-page allocation
  always_comb begin
    if (clr_active_r) begin
      map_we    = 1'b1;
      map_waddr = clr_addr_r;
      map_wdata = '0;
    end else begin
      map_we    = item_we;
      map_waddr = s1_slot_r;
      map_wdata = {1'b1, frame};
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (in_acc) begin
      map_rd_r <= map_mem[in_slot];
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == SLOT_LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload; bypass catches a map write at the same edge as the read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_va_r     <= in_chan.virtual_address;
      s1_slot_r   <= in_slot;
      byp_r       <= item_we && (s1_slot_r == in_slot);
      byp_frame_r <= frame;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r   <= '0;
      frames_used_r <= '0;
    end else if (s1_adv) begin
      hit_total_r <= hit_total_nxt;
      if (alloc && (frames_used_r != FUSED_MAX)) begin
        frames_used_r <= frames_used_r + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pa_r    <= {frame, s1_va_r[OFFS_W-1:0]};
      out_hit_r   <= lk.hit;
      out_alloc_r <= alloc;
      out_hits_r  <= hit_total_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.physical_address = out_pa_r;
  assign out_chan.tlb_hit          = out_hit_r;
  assign out_chan.frame_allocated  = out_alloc_r;
  assign out_chan.hit_count        = out_hits_r;

endmodule

FILE: hdl/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// TLB page translation - fully associative TLB
// Parallel tag search with lowest-index priority, FIFO replacement on fill.
// ----------------------------------------------------------------------------
module tlbpt_tlb #(
  parameter int ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tlbpt_pkg::PAGE_W-1:0]  lookup_page,
  output tlbpt_pkg::tlb_lookup_t        lookup,
  input  tlbpt_pkg::tlb_fill_t          fill
);
  import tlbpt_pkg::*;

  localparam int PTR_W = $clog2(ENTRIES);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

  logic [PAGE_W-1:0]  tag_r   [ENTRIES];
  logic [FRAME_W-1:0] frame_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [PTR_W-1:0]   ptr_r;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;
  logic [FRAME_W-1:0] sel_frame;

  // Tag compare on every entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == lookup_page);
    end
  end

  // Lowest matching entry wins; one-hot and-or select of its frame
  assign first = match & (~match + {{(ENTRIES-1){1'b0}}, 1'b1});

  always_comb begin
    sel_frame = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_frame = sel_frame | ({FRAME_W{first[i]}} & frame_r[i]);
    end
  end

  assign lookup.hit   = |match;
  assign lookup.frame = sel_frame;

  // Valid bits and FIFO pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else if (fill.en) begin
      valid_r[ptr_r] <= 1'b1;
      ptr_r          <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (fill.en) begin
      tag_r[ptr_r]   <= fill.tag;
      frame_r[ptr_r] <= fill.frame;
    end
  end

endmodule
